[design/bfe_pkg.sv]
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared constants, codes and types of the bytecode frame executor.
// ----------------------------------------------------------------------------
package bfe_pkg;

    // Frame size and derived index width
    localparam int LOCAL_SLOTS = 4;
    localparam int IDX_W       = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Opcodes, low byte of a first word
    localparam logic [7:0] OPC_SUSPEND  = 8'd63;
    localparam logic [7:0] OPC_SETV4    = 8'd77;
    localparam logic [7:0] OPC_ADDI     = 8'd115;
    localparam logic [7:0] OPC_CPYVTOR4 = 8'd82;
    localparam logic [7:0] OPC_RET      = 8'd10;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_OP    = 3'd1,
        ST_TRUNC     = 3'd2,
        ST_RET_NZ    = 3'd3,
        ST_NO_RET    = 3'd4,
        ST_BAD_LOCAL = 3'd5
    } status_t;

    // Work for the back part
    typedef enum logic [1:0] {
        K_NOP = 2'd0,
        K_WR  = 2'd1,
        K_ADD = 2'd2,
        K_CPY = 2'd3
    } kind_t;

    typedef struct packed {
        logic             clear;
        kind_t            kind;
        logic [IDX_W-1:0] dest;
        logic [IDX_W-1:0] src_a;
        logic [IDX_W-1:0] src_b;
        logic [31:0]      data;
        logic             emit;
        status_t          status;
    } op_t;

    typedef struct packed {
        logic push;
        op_t  op;
    } bfe_push_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } bfe_head_t;

    // True when a 16-bit local index lies inside the frame
    function automatic logic slot_ok(input logic [15:0] idx);
        return idx < 16'(LOCAL_SLOTS);
    endfunction

endpackage

[design/bfe_if.sv]
// ----------------------------------------------------------------------------
// bfe_if
// Request channels of the bytecode frame executor: words in, results out.
// ----------------------------------------------------------------------------
interface bfe_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;
    logic        start_req;
    logic        last;

    modport source (output valid, output word, output start_req, output last,
                    input ready);
    modport sink   (input valid, input word, input start_req, input last,
                    output ready);
endinterface

interface bfe_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface

[design/bfe_front.sv]
// ----------------------------------------------------------------------------
// bfe_front
// Accepts words, tracks run and pending two-word instructions, and turns each
// word taken in a run into one classified operation for the back part.
// ----------------------------------------------------------------------------
module bfe_front
    import bfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bfe_in_if.sink     in_ch,
    input  logic       q_full,
    output bfe_push_t  push
);

    typedef enum logic [2:0] {
        P_NONE = 3'b001,
        P_SET  = 3'b010,
        P_ADD  = 3'b100
    } pend_t;

    logic             running_reg, running_next;
    pend_t            pend_reg, pend_next;
    logic [IDX_W-1:0] dest_reg, dest_next;

    logic             accept;
    logic             run_eff;
    pend_t            pend;
    logic [15:0]      lo, hi;
    logic [7:0]       opc;
    op_t              op;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign lo          = in_ch.word[15:0];
    assign hi          = in_ch.word[31:16];
    assign opc         = in_ch.word[7:0];

    // Classify the word
    always_comb
    begin
        run_eff      = in_ch.start_req || running_reg;
        pend         = in_ch.start_req ? P_NONE : pend_reg;
        running_next = running_reg;
        pend_next    = pend_reg;
        dest_next    = dest_reg;
        op.clear     = in_ch.start_req;
        op.kind      = K_NOP;
        op.dest      = dest_reg;
        op.src_a     = lo[IDX_W-1:0];
        op.src_b     = hi[IDX_W-1:0];
        op.data      = in_ch.word;
        op.emit      = 1'b0;
        op.status    = ST_OK;
        if (accept && run_eff)
        begin
            running_next = 1'b1;
            pend_next    = P_NONE;
            if (pend == P_SET)
            begin
                op.kind   = K_WR;
                op.emit   = in_ch.last;
                op.status = ST_NO_RET;
            end
            else if (pend == P_ADD)
            begin
                if (!slot_ok(lo) || !slot_ok(hi))
                begin
                    op.emit   = 1'b1;
                    op.status = ST_BAD_LOCAL;
                end
                else
                begin
                    op.kind   = K_ADD;
                    op.emit   = in_ch.last;
                    op.status = ST_NO_RET;
                end
            end
            else
            begin
                case (opc)
                    OPC_SUSPEND:
                    begin
                        op.emit   = in_ch.last;
                        op.status = ST_NO_RET;
                    end
                    OPC_SETV4, OPC_ADDI:
                    begin
                        if (in_ch.last)
                        begin
                            op.emit   = 1'b1;
                            op.status = ST_TRUNC;
                        end
                        else if (!slot_ok(hi))
                        begin
                            op.emit   = 1'b1;
                            op.status = ST_BAD_LOCAL;
                        end
                        else
                        begin
                            dest_next = hi[IDX_W-1:0];
                            pend_next = (opc == OPC_SETV4) ? P_SET : P_ADD;
                        end
                    end
                    OPC_CPYVTOR4:
                    begin
                        op.src_a = hi[IDX_W-1:0];
                        if (!slot_ok(hi))
                        begin
                            op.emit   = 1'b1;
                            op.status = ST_BAD_LOCAL;
                        end
                        else
                        begin
                            op.kind   = K_CPY;
                            op.emit   = in_ch.last;
                            op.status = ST_NO_RET;
                        end
                    end
                    OPC_RET:
                    begin
                        op.emit   = 1'b1;
                        op.status = (hi != 16'd0) ? ST_RET_NZ : ST_OK;
                    end
                    default:
                    begin
                        op.emit   = 1'b1;
                        op.status = ST_BAD_OP;
                    end
                endcase
            end
            // A result ends the run
            if (op.emit)
            begin
                running_next = 1'b0;
                pend_next    = P_NONE;
            end
        end
    end

    assign push.push = accept && run_eff;
    assign push.op   = op;

    // Hold run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            pend_reg    <= P_NONE;
            dest_reg    <= '0;
        end
        else
        begin
            running_reg <= running_next;
            pend_reg    <= pend_next;
            dest_reg    <= dest_next;
        end
    end

endmodule

[design/bfe_queue.sv]
// ----------------------------------------------------------------------------
// bfe_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module bfe_queue
    import bfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  bfe_push_t push,
    input  logic      pop,
    output logic      full,
    output bfe_head_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.op    = entry_reg[rd_ptr_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = pop && head.valid;

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.op;
        end
    end

endmodule

[design/bfe_back.sv]
// ----------------------------------------------------------------------------
// bfe_back
// Carries out operations on the frame: locals memory with registered reads,
// value register, adder and the output register.
// ----------------------------------------------------------------------------
module bfe_back
    import bfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bfe_head_t  head,
    output logic       pop,
    bfe_out_if.source  out_ch
);

    logic [31:0]      mem [LOCAL_SLOTS];
    logic [LOCAL_SLOTS-1:0] vld_reg, vld_next;

    // Execute stage
    logic        ex_valid_reg;
    op_t         ex_op_reg;
    logic [31:0] mem_a_reg, mem_b_reg;
    logic        a_zero_reg, b_zero_reg;
    logic        a_fwd_reg, b_fwd_reg;
    logic [31:0] fwd_data_reg;
    logic [31:0] value_reg, value_next;

    // Output register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [31:0] out_value_reg;

    logic        out_free, ex_adv, ex_fire, wr_fire;
    logic [31:0] opnd_a, opnd_b, wr_data, base_value;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign ex_adv   = !ex_valid_reg || !ex_op_reg.emit || out_free;
    assign ex_fire  = ex_valid_reg && ex_adv;
    assign pop      = head.valid && ex_adv;
    assign wr_fire  = ex_fire && (ex_op_reg.kind == K_WR || ex_op_reg.kind == K_ADD);

    // Select operands: forwarded, cleared or read
    assign opnd_a     = a_fwd_reg ? fwd_data_reg : (a_zero_reg ? 32'd0 : mem_a_reg);
    assign opnd_b     = b_fwd_reg ? fwd_data_reg : (b_zero_reg ? 32'd0 : mem_b_reg);
    assign wr_data    = (ex_op_reg.kind == K_WR) ? ex_op_reg.data : opnd_a + opnd_b;
    assign base_value = ex_op_reg.clear ? 32'd0 : value_reg;

    // Update valid bits and value register at commit
    always_comb
    begin
        vld_next   = vld_reg;
        value_next = value_reg;
        if (ex_fire)
        begin
            if (ex_op_reg.clear)
            begin
                vld_next   = '0;
                value_next = 32'd0;
            end
            if (wr_fire)
            begin
                vld_next[ex_op_reg.dest] = 1'b1;
            end
            if (ex_op_reg.kind == K_CPY)
            begin
                value_next = opnd_a;
            end
        end
    end

    // Locals memory: write at commit, registered read on pop
    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem[ex_op_reg.dest] <= wr_data;
        end
        if (pop)
        begin
            mem_a_reg    <= mem[head.op.src_a];
            mem_b_reg    <= mem[head.op.src_b];
            fwd_data_reg <= wr_data;
            ex_op_reg    <= head.op;
        end
    end

    // Capture read selects, resolving against the committing operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
            vld_reg      <= '0;
            value_reg    <= 32'd0;
            a_zero_reg   <= 1'b0;
            b_zero_reg   <= 1'b0;
            a_fwd_reg    <= 1'b0;
            b_fwd_reg    <= 1'b0;
        end
        else
        begin
            vld_reg   <= vld_next;
            value_reg <= value_next;
            if (ex_adv)
            begin
                ex_valid_reg <= head.valid;
            end
            if (pop)
            begin
                a_fwd_reg  <= !head.op.clear && wr_fire && (ex_op_reg.dest == head.op.src_a);
                b_fwd_reg  <= !head.op.clear && wr_fire && (ex_op_reg.dest == head.op.src_b);
                a_zero_reg <= head.op.clear || (ex_fire && ex_op_reg.clear)
                              || !vld_reg[head.op.src_a];
                b_zero_reg <= head.op.clear || (ex_fire && ex_op_reg.clear)
                              || !vld_reg[head.op.src_b];
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ex_fire && ex_op_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_fire && ex_op_reg.emit)
        begin
            out_status_reg <= ex_op_reg.status;
            out_value_reg  <= (ex_op_reg.status == ST_OK) ? base_value : 32'd0;
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.status = out_status_reg;
    assign out_ch.value  = $signed(out_value_reg);

endmodule

[design/bytecode_frame_executor_top.sv]
// ----------------------------------------------------------------------------
// bytecode_frame_executor_top
// Runs a small register-only bytecode function, one word per request.
//
//   channel   dir  payload                     handshake
//   in_ch     in   word[31:0] start_req last   valid / ready
//   out_ch    out  status[2:0] value[31:0]     valid / ready
//
// One word is taken per cycle, back to back, while the queue has room. A word
// enters the queue at the edge that takes it, then moves into the execute stage
// with its locals read, and from there sets the output register.
// Reset clears run state, queue, valid bits of the locals and the value
// register at once. A result waiting in the output register stalls only the
// execute stage; the queue absorbs words until it fills, then ready drops.
// ----------------------------------------------------------------------------
module bytecode_frame_executor_top
    import bfe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bfe_in_if.sink    in_ch,
    bfe_out_if.source out_ch
);

    bfe_push_t push;
    bfe_head_t head;
    logic      q_full;
    logic      pop;

    bfe_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .push   (push)
    );

    bfe_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    bfe_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule
